### rtl/core/rectilinear_vertex_classifier_top_defines.svh
// ----------------------------------------------------------------------------
// rectilinear vertex classifier assertion macros
// shared concurrent assertion forms for the classifier rtl
// ----------------------------------------------------------------------------
`ifndef RECTILINEAR_VERTEX_CLASSIFIER_TOP_DEFINES_SVH
`define RECTILINEAR_VERTEX_CLASSIFIER_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RVC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rvc assertion failed");

// next-cycle implication, checked outside reset
`define RVC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rvc assertion failed");

`endif

### rtl/core/rvc_pkg.sv
// ----------------------------------------------------------------------------
// rvc_pkg
// types and constants of the rectilinear vertex classifier
// ----------------------------------------------------------------------------
`default_nettype none

package rvc_pkg;

  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int FRAC_BITS = 8;
  localparam int HALF_UNIT = (2**FRAC_BITS + 1) / 2;
  localparam int IDX_OUT_W = 16;
  localparam int CNT_W     = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_DOWN  = 3'd1,
    DIR_RIGHT = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_UNDEF = 3'd4
  } dir_t;

  typedef enum logic [1:0] {
    KIND_STRAIGHT = 2'd0,
    KIND_CONCAVE  = 2'd1,
    KIND_CONVEX   = 2'd2,
    KIND_INVALID  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_NOT_AXIS  = 2'd1,
    ERR_REVERSAL  = 2'd2,
    ERR_TOO_FEW   = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    SEQ_RUN    = 2'd0,
    SEQ_WRAP_A = 2'd1,
    SEQ_WRAP_B = 2'd2
  } seq_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]      vertex_index;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    kind_t                     vertex_kind;
    dir_t                      incoming_dir;
    err_t                      error_code;
    logic [CNT_W-1:0]          concave_total;
    logic                      any_failure;
    logic                      last_result;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/rvc_classify.sv
// ----------------------------------------------------------------------------
// rvc_classify
// edge directions and turn class of the middle point of three vertices
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_classify import rvc_pkg::*; (
  input  point_t pt_a,
  input  point_t pt_b,
  input  point_t pt_c,
  output dir_t   dir_in,
  output kind_t  kind,
  output err_t   err
);

  localparam logic signed [DIFF_W-1:0] HALF_POS = DIFF_W'(HALF_UNIT);
  localparam logic signed [DIFF_W-1:0] HALF_NEG = -HALF_POS;

  function automatic dir_t edge_dir(point_t a, point_t b);
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic xp, xm, yp, ym;
    dir_t d;
    dx = {b.x[COORD_W-1], b.x} - {a.x[COORD_W-1], a.x};
    dy = {b.y[COORD_W-1], b.y} - {a.y[COORD_W-1], a.y};
    xp = (dx >= HALF_POS);
    xm = (dx <= HALF_NEG);
    yp = (dy >= HALF_POS);
    ym = (dy <= HALF_NEG);
    if (!xp && !xm && yp) begin
      d = DIR_UP;
    end else if (!xp && !xm && ym) begin
      d = DIR_DOWN;
    end else if (xp && !yp && !ym) begin
      d = DIR_RIGHT;
    end else if (xm && !yp && !ym) begin
      d = DIR_LEFT;
    end else begin
      d = DIR_UNDEF;
    end
    return d;
  endfunction

  dir_t d1;
  dir_t d2;
  logic concave_turn;
  logic convex_turn;

  assign d1 = edge_dir(pt_a, pt_b);
  assign d2 = edge_dir(pt_b, pt_c);
  assign dir_in = d1;

  assign concave_turn = (d1 == DIR_RIGHT && d2 == DIR_DOWN) ||
                        (d1 == DIR_LEFT  && d2 == DIR_UP)   ||
                        (d1 == DIR_UP    && d2 == DIR_RIGHT) ||
                        (d1 == DIR_DOWN  && d2 == DIR_LEFT);
  assign convex_turn  = (d1 == DIR_RIGHT && d2 == DIR_UP)   ||
                        (d1 == DIR_LEFT  && d2 == DIR_DOWN) ||
                        (d1 == DIR_UP    && d2 == DIR_LEFT) ||
                        (d1 == DIR_DOWN  && d2 == DIR_RIGHT);

  always_comb begin
    if (d1 == DIR_UNDEF || d2 == DIR_UNDEF) begin
      kind = KIND_INVALID;
      err  = ERR_NOT_AXIS;
    end else if (d1 == d2) begin
      kind = KIND_STRAIGHT;
      err  = ERR_OK;
    end else if (concave_turn) begin
      kind = KIND_CONCAVE;
      err  = ERR_OK;
    end else if (convex_turn) begin
      kind = KIND_CONVEX;
      err  = ERR_OK;
    end else begin
      kind = KIND_INVALID;
      err  = ERR_REVERSAL;
    end
  end

endmodule

`default_nettype wire

### rtl/core/rvc_skid.sv
// ----------------------------------------------------------------------------
// rvc_skid
// result register with one skid entry between classifier and output port
// ----------------------------------------------------------------------------
`default_nettype none

module rvc_skid import rvc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  res_t push_res,
  output logic push_ready,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_res
);

  logic main_valid_r, main_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  res_t main_res_r, main_res_nxt;
  res_t skid_res_r, skid_res_nxt;

  assign push_ready = !skid_valid_r;
  assign pop_valid  = main_valid_r;
  assign pop_res    = main_res_r;

  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    main_res_nxt   = main_res_r;
    skid_res_nxt   = skid_res_r;
    if (!main_valid_r || pop_ready) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        main_res_nxt   = skid_res_r;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = push_valid;
        main_res_nxt   = push_res;
      end
    end else if (push_valid) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_res_r <= main_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

endmodule

`default_nettype wire

### rtl/core/rectilinear_vertex_classifier_top.sv
// ----------------------------------------------------------------------------
// rectilinear_vertex_classifier_top
// classifies the vertices of an axis-aligned polygon as straight, concave,
// convex or invalid and counts concave vertices
// ----------------------------------------------------------------------------
// usage
// - in_*: one vertex per word, anticlockwise, in_tlast on the last vertex
// - out_*: one classified vertex per word, out_tlast on the polygon's last
// - vertex k is classified when vertex k+1 is accepted; the last
//   vertex of a polygon yields three words (second to last, last, vertex 0)
// - a polygon of fewer than three vertices yields one error word
// - throughput: one vertex per cycle while the output does not stall; the last
//   vertex of a polygon of three or more holds in_tready low in SEQ_WRAP_A and
//   SEQ_WRAP_B while the wrap-around words go through the single classifier
// - output register plus one skid entry: input keeps flowing for one word
//   of output stall, then in_tready drops until out_tready returns
// - reset clears the vertex count, concave count and failure flag; no
//   word is pending after reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "rectilinear_vertex_classifier_top_defines.svh"

module rectilinear_vertex_classifier_top import rvc_pkg::*; #(
  parameter int MAX_VERTICES = 65536
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // coord_x, coord_y
  input  logic         in_tlast,   // final_vertex
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // vertex_index, vertex_x, vertex_y, vertex_kind,
                                   // incoming_dir, error_code, concave_total, any_failure
  output logic         out_tlast   // last_result
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int PTS_W = $clog2(MAX_VERTICES + 1);
  localparam logic [PTS_W-1:0] PTS_MAX = PTS_W'(MAX_VERTICES);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(MAX_VERTICES - 1);

  seq_t             state_r, state_nxt;
  logic [PTS_W-1:0] pts_r, pts_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             fail_r, fail_nxt;
  point_t           first_r, first_nxt;
  point_t           second_r, second_nxt;
  point_t           older_r, older_nxt;
  point_t           newer_r, newer_nxt;

  point_t           in_pt;
  logic             push_ready;
  logic             push_valid;
  res_t             push_res;
  res_t             out_res;
  logic             acc;

  point_t           cls_a, cls_b, cls_c;
  dir_t             cls_dir;
  kind_t            cls_kind;
  err_t             cls_err;
  logic [CNT_W-1:0] cnt_cls;
  logic             fail_cls;
  logic [IDX_W-1:0] idx_cur;
  logic [IDX_W-1:0] idx_sel;
  logic [31:0]      idx_wide;

  assign in_pt.x = in_tdata[31:0];
  assign in_pt.y = in_tdata[63:32];

  assign in_tready = push_ready && (state_r == SEQ_RUN);
  assign acc       = in_tvalid && in_tready;

  assign idx_cur  = (pts_r < PTS_MAX) ? pts_r[IDX_W-1:0] : IDX_TOP;
  assign idx_wide = 32'(idx_sel);

  always_comb begin
    case (state_r)
      SEQ_WRAP_A: begin
        cls_a = older_r;
        cls_b = newer_r;
        cls_c = first_r;
      end
      SEQ_WRAP_B: begin
        cls_a = newer_r;
        cls_b = first_r;
        cls_c = second_r;
      end
      default: begin
        cls_a = older_r;
        cls_b = newer_r;
        cls_c = in_pt;
      end
    endcase
  end

  rvc_classify u_classify (
    .pt_a   (cls_a),
    .pt_b   (cls_b),
    .pt_c   (cls_c),
    .dir_in (cls_dir),
    .kind   (cls_kind),
    .err    (cls_err)
  );

  assign cnt_cls  = (cls_kind == KIND_CONCAVE && cnt_r != CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  assign fail_cls = fail_r || (cls_err != ERR_OK);

  always_comb begin
    state_nxt  = state_r;
    pts_nxt    = pts_r;
    cnt_nxt    = cnt_r;
    fail_nxt   = fail_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    push_valid = 1'b0;
    idx_sel    = idx_cur - IDX_W'(1);

    push_res.vertex_index  = idx_wide[IDX_OUT_W-1:0];
    push_res.vertex_x      = cls_b.x;
    push_res.vertex_y      = cls_b.y;
    push_res.vertex_kind   = cls_kind;
    push_res.incoming_dir  = cls_dir;
    push_res.error_code    = cls_err;
    push_res.concave_total = cnt_cls;
    push_res.any_failure   = fail_cls;
    push_res.last_result   = 1'b0;

    case (state_r)
      SEQ_RUN: begin
        if (acc) begin
          if (pts_r == PTS_W'(0)) begin
            first_nxt = in_pt;
          end
          if (pts_r == PTS_W'(1)) begin
            second_nxt = in_pt;
          end
          older_nxt = newer_r;
          newer_nxt = in_pt;
          if (pts_r < PTS_MAX) begin
            pts_nxt = pts_r + PTS_W'(1);
          end
          if (pts_r >= PTS_W'(2)) begin
            push_valid = 1'b1;
            cnt_nxt    = cnt_cls;
            fail_nxt   = fail_cls;
            if (in_tlast) begin
              state_nxt = SEQ_WRAP_A;
            end
          end else if (in_tlast) begin
            // too few vertices: one error word for vertex 0
            push_valid             = 1'b1;
            push_res.vertex_index  = '0;
            push_res.vertex_x      = (pts_r == PTS_W'(0)) ? in_pt.x : first_r.x;
            push_res.vertex_y      = (pts_r == PTS_W'(0)) ? in_pt.y : first_r.y;
            push_res.vertex_kind   = KIND_INVALID;
            push_res.incoming_dir  = DIR_UNDEF;
            push_res.error_code    = ERR_TOO_FEW;
            push_res.concave_total = '0;
            push_res.any_failure   = 1'b1;
            push_res.last_result   = 1'b1;
            pts_nxt                = '0;
            cnt_nxt                = '0;
            fail_nxt               = 1'b0;
          end
        end
      end
      SEQ_WRAP_A: begin
        idx_sel = pts_r[IDX_W-1:0] - IDX_W'(1);
        if (pts_r == PTS_MAX) begin
          idx_sel = IDX_TOP;
        end
        if (push_ready) begin
          push_valid = 1'b1;
          cnt_nxt    = cnt_cls;
          fail_nxt   = fail_cls;
          state_nxt  = SEQ_WRAP_B;
        end
      end
      SEQ_WRAP_B: begin
        idx_sel              = '0;
        push_res.last_result = 1'b1;
        if (push_ready) begin
          push_valid = 1'b1;
          pts_nxt    = '0;
          cnt_nxt    = '0;
          fail_nxt   = 1'b0;
          state_nxt  = SEQ_RUN;
        end
      end
      default: begin
        state_nxt = SEQ_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_RUN;
      pts_r   <= '0;
      cnt_r   <= '0;
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pts_r   <= pts_nxt;
      cnt_r   <= cnt_nxt;
      fail_r  <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    first_r  <= first_nxt;
    second_r <= second_nxt;
    older_r  <= older_nxt;
    newer_r  <= newer_nxt;
  end

  rvc_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_res   (push_res),
    .push_ready (push_ready),
    .pop_valid  (out_tvalid),
    .pop_ready  (out_tready),
    .pop_res    (out_res)
  );

  assign out_tdata = {out_res.any_failure, out_res.concave_total, out_res.error_code,
                      out_res.incoming_dir, out_res.vertex_kind, out_res.vertex_y,
                      out_res.vertex_x, out_res.vertex_index};
  assign out_tlast = out_res.last_result;

  `RVC_ASSERT_NEXT(a_wrap_order, clk, rst_n, (state_r == SEQ_WRAP_A) && push_ready, state_r == SEQ_WRAP_B)
  `RVC_ASSERT_NEXT(a_end_clears, clk, rst_n, push_valid && push_res.last_result, (pts_r == '0) && (cnt_r == '0) && !fail_r)
  `RVC_ASSERT_IMPL(a_err_sticky, clk, rst_n, push_valid && (push_res.error_code != ERR_OK), push_res.any_failure)
  `RVC_ASSERT_IMPL(a_wrap_count, clk, rst_n, state_r != SEQ_RUN, pts_r >= PTS_W'(3))

endmodule

`default_nettype wire
